// ===== hdl/prelu_pkg.sv =====
// Shared types and constants for the PReLU forward/backward engine.
// No dependencies; the other files that use it refer to it by scoped names.
package prelu_pkg;

  // Fixed field widths of the item format
  localparam int CFG_W      = 16;
  localparam int CHAN_IDX_W = 6;
  localparam int CNT_W      = 7;
  localparam int SPATIAL_W  = 16;

  // Operation codes of an input word
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_FORWARD = 2'd1,
    OP_IN_GRAD = 2'd2,
    OP_ACCUM   = 2'd3
  } op_e;

  // Configuration register indexes
  localparam logic [1:0] REG_LAYOUT   = 2'd0;
  localparam logic [1:0] REG_CHANNELS = 2'd1;
  localparam logic [1:0] REG_SPATIAL  = 2'd2;

  // Layout codes
  localparam logic LAYOUT_SPATIAL_INNER = 1'b0;

  // Effective (clamped) configuration
  typedef struct packed {
    logic                 layout;
    logic [CNT_W-1:0]     chan_cnt;
    logic [SPATIAL_W-1:0] plane_cnt;
  } cfg_t;

  // Position counter control
  typedef struct packed {
    logic step;
    logic restart;
  } pos_ctrl_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DONE,
    ST_FLUSH_RD,
    ST_FLUSH_OUT
  } state_e;

endpackage

// ===== hdl/prelu_if.sv =====
// Valid/ready channel interfaces for input and result words.
// Depends on prelu_pkg for fixed field widths.
interface prelu_in_if #(parameter int DW = 16) ();
  logic                             valid;
  logic                             ready;
  logic [1:0]                       operation;
  logic signed [DW-1:0]             x_value;
  logic signed [DW-1:0]             grad_value;
  logic signed [DW-1:0]             slope_value;
  logic [prelu_pkg::CHAN_IDX_W-1:0] slope_index;
  logic                             last_item;

  modport source (output valid, operation, x_value, grad_value, slope_value,
                  slope_index, last_item, input ready);
  modport sink (input valid, operation, x_value, grad_value, slope_value,
                slope_index, last_item, output ready);
endinterface

interface prelu_out_if #(parameter int DW = 16) ();
  logic                             valid;
  logic                             ready;
  logic signed [DW-1:0]             result_value;
  logic signed [2*DW-1:0]           slope_grad;
  logic [prelu_pkg::CHAN_IDX_W-1:0] result_channel;
  logic                             result_kind;
  logic                             result_last;

  modport source (output valid, result_value, slope_grad, result_channel,
                  result_kind, result_last, input ready);
  modport sink (input valid, result_value, slope_grad, result_channel,
                result_kind, result_last, output ready);
endinterface

// ===== hdl/prelu_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module prelu_ram #(
  parameter int Width = 16,
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/prelu_pos.sv =====
// Element position counter: channel and plane position per layout.
// Depends on prelu_pkg (cfg_t, pos_ctrl_t).
module prelu_pos #(
  parameter int ChW = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  prelu_pkg::cfg_t       cfg_i,
  input  prelu_pkg::pos_ctrl_t  ctrl_i,
  output logic [ChW-1:0]        chan_o
);

  logic [ChW-1:0]                  chan_q, chan_d;
  logic [prelu_pkg::SPATIAL_W-1:0] plane_q, plane_d;
  logic                            chan_wrap, plane_wrap;

  // wrap when the next value reaches the limit (also catches stale counters)
  assign chan_wrap  = (prelu_pkg::CNT_W'(chan_q) + prelu_pkg::CNT_W'(1)) >= cfg_i.chan_cnt;
  assign plane_wrap = ((prelu_pkg::SPATIAL_W+1)'(plane_q) + (prelu_pkg::SPATIAL_W+1)'(1))
                      >= (prelu_pkg::SPATIAL_W+1)'(cfg_i.plane_cnt);

  always_comb begin
    chan_d  = chan_q;
    plane_d = plane_q;
    if (ctrl_i.restart) begin
      chan_d  = '0;
      plane_d = '0;
    end else if (ctrl_i.step) begin
      if (cfg_i.layout == prelu_pkg::LAYOUT_SPATIAL_INNER) begin
        if (plane_wrap) begin
          plane_d = '0;
          chan_d  = chan_wrap ? '0 : chan_q + ChW'(1);
        end else begin
          plane_d = plane_q + prelu_pkg::SPATIAL_W'(1);
        end
      end else begin
        if (chan_wrap) begin
          chan_d  = '0;
          plane_d = plane_wrap ? '0 : plane_q + prelu_pkg::SPATIAL_W'(1);
        end else begin
          chan_d = chan_q + ChW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q  <= '0;
      plane_q <= '0;
    end else begin
      chan_q  <= chan_d;
      plane_q <= plane_d;
    end
  end

  assign chan_o = chan_q;

endmodule

// ===== hdl/prelu_forward_backward_engine.sv =====
// PReLU engine: forward, input gradient and slope gradient in fixed point.
// Load words write the slope table in idle. Others pass the multiply and done states
// and the next word is taken back in idle; forward / input gradient results wait in
// done for a free output. A last accumulate walks the sums from the sum RAM port.
// Reset: default config; clears position, output valid, sum valid bits (sums read 0).
// Depends on prelu_pkg, prelu_if, prelu_ram and prelu_pos.
module prelu_forward_backward_engine #(
  parameter int MAX_CHANNELS = 64,
  parameter int DATA_WIDTH   = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  prelu_in_if.sink                    in_ch,
  prelu_out_if.source                 out_ch,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [prelu_pkg::CFG_W-1:0] cfg_wdata_i
);

  localparam int FRAC   = DATA_WIDTH / 2;
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int ACC_W  = 3 * DATA_WIDTH;
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [PROD_W:0] HALF = (PROD_W+1)'(1) << (FRAC - 1);

  // configuration registers
  logic                            layout_q;
  logic [prelu_pkg::CNT_W-1:0]     chan_cnt_q;
  logic [prelu_pkg::SPATIAL_W-1:0] plane_cnt_q;
  prelu_pkg::cfg_t                 cfg_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q    <= 1'b0;
      chan_cnt_q  <= prelu_pkg::CNT_W'(1);
      plane_cnt_q <= prelu_pkg::SPATIAL_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        prelu_pkg::REG_LAYOUT:   layout_q    <= cfg_wdata_i[0];
        prelu_pkg::REG_CHANNELS: chan_cnt_q  <= cfg_wdata_i[prelu_pkg::CNT_W-1:0];
        prelu_pkg::REG_SPATIAL:  plane_cnt_q <= cfg_wdata_i[prelu_pkg::SPATIAL_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp counts into their legal range
  always_comb begin
    cfg_eff.layout    = layout_q;
    cfg_eff.chan_cnt  = chan_cnt_q;
    cfg_eff.plane_cnt = plane_cnt_q;
    if (chan_cnt_q == '0) begin
      cfg_eff.chan_cnt = prelu_pkg::CNT_W'(1);
    end else if (chan_cnt_q > prelu_pkg::CNT_W'(MAX_CHANNELS)) begin
      cfg_eff.chan_cnt = prelu_pkg::CNT_W'(MAX_CHANNELS);
    end
    if (plane_cnt_q == '0) begin
      cfg_eff.plane_cnt = prelu_pkg::SPATIAL_W'(1);
    end
  end

  // sequencer and item registers
  prelu_pkg::state_e    state_q, state_d;
  prelu_pkg::op_e       op_in, op_q;
  logic signed [DATA_WIDTH-1:0] x_q, dy_q;
  logic                 last_q;
  logic [CH_W-1:0]      ch_q, pos_chan, flush_k_q;
  logic                 accept, elem_op_in;
  logic                 out_free, out_load, flush_last;
  logic                 sum_we, sum_re, vld_clear;
  prelu_pkg::pos_ctrl_t pos_ctrl;

  assign op_in      = prelu_pkg::op_e'(in_ch.operation);
  assign accept     = in_ch.valid && in_ch.ready;
  assign elem_op_in = (op_in != prelu_pkg::OP_LOAD);
  assign out_free   = !out_ch.valid || out_ch.ready;
  assign flush_last = (prelu_pkg::CNT_W'(flush_k_q) + prelu_pkg::CNT_W'(1)) == cfg_eff.chan_cnt;

  assign pos_ctrl.step    = accept && elem_op_in && !in_ch.last_item;
  assign pos_ctrl.restart = accept && elem_op_in && in_ch.last_item;

  prelu_pos #(.ChW(CH_W)) u_pos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_eff),
    .ctrl_i (pos_ctrl),
    .chan_o (pos_chan)
  );

  // slope table
  logic                  slope_we;
  logic [DATA_WIDTH-1:0] slope_rd;

  assign slope_we = accept && (op_in == prelu_pkg::OP_LOAD)
                    && (32'(in_ch.slope_index) < 32'(MAX_CHANNELS));

  prelu_ram #(.Width(DATA_WIDTH), .Depth(MAX_CHANNELS), .AddrW(CH_W)) u_slope_ram (
    .clk_i   (clk_i),
    .we_i    (slope_we),
    .waddr_i (in_ch.slope_index[CH_W-1:0]),
    .wdata_i (in_ch.slope_value),
    .re_i    (accept),
    .raddr_i (pos_chan),
    .rdata_o (slope_rd)
  );

  // gradient sums
  logic [ACC_W-1:0]        sum_rd, sum_wdata;
  logic [MAX_CHANNELS-1:0] sum_vld_q;

  prelu_ram #(.Width(ACC_W), .Depth(MAX_CHANNELS), .AddrW(CH_W)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (ch_q),
    .wdata_i (sum_wdata),
    .re_i    (sum_re),
    .raddr_i ((state_q == prelu_pkg::ST_FLUSH_RD) ? flush_k_q : pos_chan),
    .rdata_o (sum_rd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      prelu_pkg::ST_IDLE: begin
        if (accept && elem_op_in) state_d = prelu_pkg::ST_MUL;
      end
      prelu_pkg::ST_MUL: state_d = prelu_pkg::ST_DONE;
      prelu_pkg::ST_DONE: begin
        if (op_q == prelu_pkg::OP_ACCUM) begin
          state_d = last_q ? prelu_pkg::ST_FLUSH_RD : prelu_pkg::ST_IDLE;
        end else if (out_free) begin
          state_d = prelu_pkg::ST_IDLE;
        end
      end
      prelu_pkg::ST_FLUSH_RD: state_d = prelu_pkg::ST_FLUSH_OUT;
      prelu_pkg::ST_FLUSH_OUT: begin
        if (out_free) state_d = flush_last ? prelu_pkg::ST_IDLE : prelu_pkg::ST_FLUSH_RD;
      end
      default: state_d = prelu_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    sum_we      = 1'b0;
    sum_re      = 1'b0;
    vld_clear   = 1'b0;
    case (state_q)
      prelu_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        sum_re      = in_ch.valid;
      end
      prelu_pkg::ST_DONE: begin
        sum_we   = (op_q == prelu_pkg::OP_ACCUM) && !(x_q > 0);
        out_load = (op_q != prelu_pkg::OP_ACCUM) && out_free;
      end
      prelu_pkg::ST_FLUSH_RD: sum_re = 1'b1;
      prelu_pkg::ST_FLUSH_OUT: begin
        out_load  = out_free;
        vld_clear = out_free && flush_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= prelu_pkg::ST_IDLE;
      flush_k_q <= '0;
      sum_vld_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == prelu_pkg::ST_DONE) begin
        flush_k_q <= '0;
      end else if (state_q == prelu_pkg::ST_FLUSH_OUT && out_free) begin
        flush_k_q <= flush_k_q + CH_W'(1);
      end
      if (vld_clear) begin
        sum_vld_q <= '0;
      end else if (sum_we) begin
        sum_vld_q[ch_q] <= 1'b1;
      end
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_in;
      x_q    <= in_ch.x_value;
      dy_q   <= in_ch.grad_value;
      last_q <= in_ch.last_item;
      ch_q   <= pos_chan;
    end
  end

  // multiply stage
  logic signed [DATA_WIDTH-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]     prod_q;
  logic [ACC_W-1:0]             base_q;

  assign mul_a = (op_q == prelu_pkg::OP_FORWARD) ? x_q : dy_q;
  assign mul_b = (op_q == prelu_pkg::OP_ACCUM) ? x_q : $signed(slope_rd);

  always_ff @(posedge clk_i) begin
    if (state_q == prelu_pkg::ST_MUL) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
      base_q <= sum_vld_q[ch_q] ? sum_rd : '0;
    end
  end

  // round half up, then saturate to the data width
  logic signed [PROD_W:0]       rnd_sum, rnd_shift;
  logic [PROD_W-DATA_WIDTH+1:0] rnd_top;
  logic signed [DATA_WIDTH-1:0] rnd_sat, elem_val;

  assign rnd_sum   = $signed({prod_q[PROD_W-1], prod_q} + HALF);
  assign rnd_shift = rnd_sum >>> FRAC;
  assign rnd_top   = rnd_shift[PROD_W:DATA_WIDTH-1];
  assign rnd_sat   = ((&rnd_top) || !(|rnd_top)) ? rnd_shift[DATA_WIDTH-1:0]
                   : {rnd_shift[PROD_W], {(DATA_WIDTH-1){~rnd_shift[PROD_W]}}};
  assign elem_val  = (x_q > 0) ? mul_a : rnd_sat;

  // accumulate with saturation on the sum width
  logic [ACC_W:0] acc_sum;

  assign acc_sum   = {base_q[ACC_W-1], base_q}
                   + {{(ACC_W-PROD_W+1){prod_q[PROD_W-1]}}, prod_q};
  assign sum_wdata = (acc_sum[ACC_W] == acc_sum[ACC_W-1]) ? acc_sum[ACC_W-1:0]
                   : {acc_sum[ACC_W], {(ACC_W-1){~acc_sum[ACC_W]}}};

  // emitted sum saturated to the Q16.16 word
  logic [ACC_W-1:0]        flush_sum;
  logic [ACC_W-PROD_W:0]   flush_top;
  logic [PROD_W-1:0]       flush_sat;

  assign flush_sum = sum_vld_q[flush_k_q] ? sum_rd : '0;
  assign flush_top = flush_sum[ACC_W-1:PROD_W-1];
  assign flush_sat = ((&flush_top) || !(|flush_top)) ? flush_sum[PROD_W-1:0]
                   : {flush_sum[ACC_W-1], {(PROD_W-1){~flush_sum[ACC_W-1]}}};

  // output register
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] out_value_q;
  logic [PROD_W-1:0]     out_grad_q;
  logic [prelu_pkg::CHAN_IDX_W-1:0] out_chan_q;
  logic                  out_kind_q, out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (state_q == prelu_pkg::ST_FLUSH_OUT) begin
        out_value_q <= '0;
        out_grad_q  <= flush_sat;
        out_chan_q  <= prelu_pkg::CHAN_IDX_W'(flush_k_q);
        out_kind_q  <= 1'b1;
        out_last_q  <= flush_last;
      end else begin
        out_value_q <= elem_val;
        out_grad_q  <= '0;
        out_chan_q  <= prelu_pkg::CHAN_IDX_W'(ch_q);
        out_kind_q  <= 1'b0;
        out_last_q  <= 1'b1;
      end
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.result_value   = out_value_q;
  assign out_ch.slope_grad     = out_grad_q;
  assign out_ch.result_channel = out_chan_q;
  assign out_ch.result_kind    = out_kind_q;
  assign out_ch.result_last    = out_last_q;

`ifndef NO_ASSERTIONS
  // flush walk stays inside the configured channels
  a_flush_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == prelu_pkg::ST_FLUSH_RD || state_q == prelu_pkg::ST_FLUSH_OUT)
    |-> (prelu_pkg::CNT_W'(flush_k_q) < cfg_eff.chan_cnt))
    else $error("flush index past channel count");

  // finishing a flush leaves every sum cleared
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_clear |=> (sum_vld_q == '0))
    else $error("sums not cleared after flush");

  // an element word goes straight to the multiply stage
  a_accept_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && elem_op_in) |=> (state_q == prelu_pkg::ST_MUL))
    else $error("element word not sequenced");

  // element results never carry a sum and are always marked last
  a_elem_no_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.result_kind) |-> (out_ch.slope_grad == '0 && out_ch.result_last))
    else $error("element result carries sum data");
`endif

endmodule
